// ===== src/dpgf_pkg.sv =====
package dpgf_pkg;

    localparam int POSITION_WIDTH_DEF   = 32;
    localparam int QUATERNION_WIDTH_DEF = 32;

    localparam int STAMP_W = 63;
    localparam int OPOS_W  = 32;
    localparam int OQ_W    = 30;

    // result tdata layout, lowest bit up
    localparam int OPOS_LO = STAMP_W;
    localparam int OQ_LO   = OPOS_LO + 3 * OPOS_W;
    localparam int ODATA_W = ((OQ_LO + 4 * OQ_W + 7) / 8) * 8;

    localparam int APB_AW = 5;
    localparam int CNT_W  = 5;

    localparam logic [31:0] SYNC_WINDOW_RST   = 32'd50000000;
    localparam logic [31:0] POSITION_GATE_RST = 32'd164;
    localparam logic [28:0] ANGLE_GATE_RST    = 29'd266138991;
    localparam logic [16:0] LEFT_SHARE_RST    = 17'd32768;
    localparam logic [16:0] SHARE_ONE         = 17'd65536;
    localparam logic [29:0] Q_ONE             = 30'd268435456;

    typedef enum logic [1:0] {
        KIND_FUSED = 2'd0,
        KIND_LEFT  = 2'd1,
        KIND_RIGHT = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        REG_SYNC_WINDOW   = 3'd0,
        REG_POSITION_GATE = 3'd1,
        REG_ANGLE_GATE    = 3'd2,
        REG_LEFT_SHARE    = 3'd3,
        REG_SINGLE_ENABLE = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        NS_LEFT  = 2'd0,
        NS_RIGHT = 2'd1,
        NS_FUSED = 2'd2,
        NS_CUR   = 2'd3
    } norm_sel_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WIN,
        ST_DSQ,
        ST_N_LOAD,
        ST_N_SHIFT,
        ST_N_SQ,
        ST_N_SQRT,
        ST_N_DIVI,
        ST_N_DIV,
        ST_N_DONE,
        ST_DOT,
        ST_GATE,
        ST_BLEND,
        ST_QBLEND,
        ST_SINGLE,
        ST_EMIT
    } state_t;

endpackage

// ===== src/dual_pose_gated_fusion_unit.sv =====
// Dual-camera pose fusion. Each input transaction carries one pose (stamp, Q16.16 position,
// Q4.28 quaternion of any norm) from the left or right camera, selected by s_tuser. The latest
// pose of each side is kept. When both sides are present, their stamps lie within the sync
// window and they pass the squared-distance and cosine gates, one fused pose (kind 0) is sent
// with the later stamp; otherwise the received pose is sent with its quaternion normalized
// (kind 1 left, kind 2 right) if single output is enabled, or nothing is sent. The block takes
// one pose at a time: all arithmetic runs on one shared multiplier plus a one-bit-per-cycle
// square root and divider under a sequencer. A single-side result takes one normalization
// (shift search, square sum, 32 square root steps, four divisions); a fused result takes
// three normalizations plus the multiply-accumulate steps, and so does a single-side result
// after a failed gate. A zero quaternion skips its normalization. A finished result waits
// in the output register, and the next pose is accepted meanwhile.
module dual_pose_gated_fusion_unit
    import dpgf_pkg::*;
#(
    parameter int POSITION_WIDTH   = POSITION_WIDTH_DEF,
    parameter int QUATERNION_WIDTH = QUATERNION_WIDTH_DEF,
    localparam int IDATA_W =
        ((STAMP_W + 3 * POSITION_WIDTH + 4 * QUATERNION_WIDTH + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                s_tvalid,
    output logic                s_tready,
    // stamp_ns, pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w
    input  logic [IDATA_W-1:0]  s_tdata,
    // camera_side
    input  logic [0:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // out_stamp_ns, out_pos_x, out_pos_y, out_pos_z, out_quat_x, out_quat_y, out_quat_z,
    // out_quat_w
    output logic [ODATA_W-1:0]  m_tdata,
    // result_kind
    output logic [1:0]          m_tuser
);

    localparam int PW = POSITION_WIDTH;
    localparam int QW = QUATERNION_WIDTH;
    localparam int MW = (PW + 1 > 32) ? PW + 1 : 32;
    localparam int IPOS_LO = STAMP_W;
    localparam int IQ_LO   = STAMP_W + 3 * PW;

    // configuration
    logic [31:0] win_reg, win_next;
    logic [31:0] pgate_reg, pgate_next;
    logic [28:0] agate_reg, agate_next;
    logic [16:0] wl_reg, wl_next;
    logic        single_en_reg, single_en_next;

    // control
    state_t          state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]      k_reg, k_next;
    norm_sel_t       nsel_reg, nsel_next;
    logic            lpres_reg, lpres_next, rpres_reg, rpres_next;
    logic            m_tvalid_reg, m_tvalid_next;

    // payload
    logic signed [PW-1:0] lpos_reg[3], lpos_next[3], rpos_reg[3], rpos_next[3];
    logic signed [QW-1:0] lori_reg[4], lori_next[4], rori_reg[4], rori_next[4];
    logic [STAMP_W-1:0]   lstamp_reg, lstamp_next, rstamp_reg, rstamp_next;
    logic [STAMP_W-1:0]   diff_reg, diff_next;
    logic                 lge_reg, lge_next, side_reg, side_next;
    logic signed [63:0]   prod_reg, prod_next, acc_reg, acc_next, dot_reg, dot_next;
    logic [49:0]          dsq_reg, dsq_next;
    logic [63:0]          mag_reg[4], mag_next[4];
    logic [3:0]           neg_reg, neg_next;
    logic [63:0]          v_reg, v_next, res_reg, res_next, bit_reg, bit_next;
    logic [29:0]          rem_reg, rem_next;
    logic [28:0]          numlo_reg, numlo_next, quo_reg, quo_next;
    logic signed [29:0]   nout_reg[4], nout_next[4];
    logic signed [29:0]   ql_reg[4], ql_next[4], qr_reg[4], qr_next[4];
    logic signed [46:0]   qf_reg[4], qf_next[4];
    logic [31:0]          fpos_reg[3], fpos_next[3];
    logic [1:0]           mkind_reg, mkind_next;
    logic [STAMP_W-1:0]   mstamp_reg, mstamp_next;
    logic [OPOS_W-1:0]    mpos_reg[3], mpos_next[3];
    logic [OQ_W-1:0]      mq_reg[4], mq_next[4];

    // shared multiplier
    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [2*MW-1:0] mul_p;

    logic        s_accept, cfg_we, both_present, win_ok, gate_pass;
    logic        sh_zero, sh_right, sh_left, emit_fire;
    logic [63:0] orv;
    logic [16:0] wr;
    logic signed [63:0] ang_t;
    logic [1:0]  ix;
    logic [2:0]  jx;

    assign pready   = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign cfg_we   = psel && penable && pwrite;
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = mkind_reg;
    assign m_tdata  = {{(ODATA_W - OQ_LO - 4 * OQ_W){1'b0}}, mq_reg[3], mq_reg[2], mq_reg[1],
                       mq_reg[0], mpos_reg[2], mpos_reg[1], mpos_reg[0], mstamp_reg};

    assign wr           = SHARE_ONE - wl_reg;
    assign both_present = lpres_reg && rpres_reg;
    assign win_ok       = (diff_reg <= STAMP_W'(win_reg));
    assign ang_t        = $signed({7'b0, agate_reg, 28'b0});
    assign gate_pass    = (dsq_reg <= 50'(pgate_reg)) && ((dot_reg >= ang_t) ||
                          (dot_reg <= -ang_t));
    assign orv          = mag_reg[0] | mag_reg[1] | mag_reg[2] | mag_reg[3];
    assign sh_zero      = (orv == 64'd0);
    assign sh_right     = |orv[63:29];
    assign sh_left      = !(|orv[63:28]);
    assign emit_fire    = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);
    assign ix           = cnt_reg[1:0];
    assign jx           = 3'(cnt_reg - CNT_W'(1));

    // register read
    always_comb begin
        case (reg_idx_t'(paddr[4:2]))
            REG_SYNC_WINDOW:   prdata = win_reg;
            REG_POSITION_GATE: prdata = pgate_reg;
            REG_ANGLE_GATE:    prdata = 32'(agate_reg);
            REG_LEFT_SHARE:    prdata = 32'(wl_reg);
            REG_SINGLE_ENABLE: prdata = 32'(single_en_reg);
            default:           prdata = 32'd0;
        endcase
    end

    // register write
    always_comb begin
        win_next       = win_reg;
        pgate_next     = pgate_reg;
        agate_next     = agate_reg;
        wl_next        = wl_reg;
        single_en_next = single_en_reg;
        if (cfg_we) begin
            case (reg_idx_t'(paddr[4:2]))
                REG_SYNC_WINDOW:   win_next = pwdata;
                REG_POSITION_GATE: pgate_next = pwdata;
                REG_ANGLE_GATE:    agate_next = pwdata[28:0];
                REG_LEFT_SHARE: begin
                    wl_next = (pwdata[16:0] > SHARE_ONE) ? SHARE_ONE : pwdata[16:0];
                end
                REG_SINGLE_ENABLE: single_en_next = pwdata[0];
                default: ;
            endcase
        end
    end

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (s_accept) state_next = ST_CHECK;
            ST_CHECK:   state_next = both_present ? ST_WIN : ST_SINGLE;
            ST_WIN:     state_next = win_ok ? ST_DSQ : ST_SINGLE;
            ST_DSQ:     if (cnt_reg == CNT_W'(3)) state_next = ST_N_LOAD;
            ST_N_LOAD:  state_next = ST_N_SHIFT;
            ST_N_SHIFT: begin
                if (sh_zero) begin
                    state_next = ST_N_DONE;
                end else if (!sh_right && !sh_left) begin
                    state_next = ST_N_SQ;
                end
            end
            ST_N_SQ:    if (cnt_reg == CNT_W'(4)) state_next = ST_N_SQRT;
            ST_N_SQRT:  if (cnt_reg == CNT_W'(31)) state_next = ST_N_DIVI;
            ST_N_DIVI:  state_next = ST_N_DIV;
            ST_N_DIV: begin
                if (cnt_reg == CNT_W'(28)) begin
                    state_next = (k_reg == 2'd3) ? ST_N_DONE : ST_N_DIVI;
                end
            end
            ST_N_DONE: begin
                case (nsel_reg)
                    NS_LEFT:  state_next = ST_N_LOAD;
                    NS_RIGHT: state_next = ST_DOT;
                    default:  state_next = ST_EMIT;
                endcase
            end
            ST_DOT:     if (cnt_reg == CNT_W'(4)) state_next = ST_GATE;
            ST_GATE:    state_next = gate_pass ? ST_BLEND : ST_SINGLE;
            ST_BLEND:   if (cnt_reg == CNT_W'(6)) state_next = ST_QBLEND;
            ST_QBLEND:  if (cnt_reg == CNT_W'(8)) state_next = ST_N_LOAD;
            ST_SINGLE:  state_next = single_en_reg ? ST_N_LOAD : ST_IDLE;
            ST_EMIT:    if (emit_fire) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // multiplier operand select: issue term cnt while the registered product of term cnt-1 is accumulated
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_DSQ: begin
                if (cnt_reg < CNT_W'(3)) begin
                    mul_a = MW'((PW + 1)'(lpos_reg[ix]) - (PW + 1)'(rpos_reg[ix]));
                    mul_b = mul_a;
                end
            end
            ST_N_SQ: begin
                if (cnt_reg < CNT_W'(4)) begin
                    mul_a = MW'($signed({1'b0, mag_reg[ix][28:0]}));
                    mul_b = mul_a;
                end
            end
            ST_DOT: begin
                if (cnt_reg < CNT_W'(4)) begin
                    mul_a = MW'(ql_reg[ix]);
                    mul_b = MW'(qr_reg[ix]);
                end
            end
            ST_BLEND: begin
                if (cnt_reg < CNT_W'(6)) begin
                    if (cnt_reg[0]) begin
                        mul_a = MW'($signed({1'b0, wr}));
                        mul_b = MW'(rpos_reg[cnt_reg[2:1]]);
                    end else begin
                        mul_a = MW'($signed({1'b0, wl_reg}));
                        mul_b = MW'(lpos_reg[cnt_reg[2:1]]);
                    end
                end
            end
            ST_QBLEND: begin
                if (cnt_reg < CNT_W'(8)) begin
                    if (cnt_reg[0]) begin
                        mul_a = MW'($signed({1'b0, wr}));
                        mul_b = MW'(qr_reg[cnt_reg[2:1]]);
                    end else begin
                        mul_a = MW'($signed({1'b0, wl_reg}));
                        mul_b = MW'(ql_reg[cnt_reg[2:1]]);
                    end
                end
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // datapath
    always_comb begin
        logic signed [63:0] src[4];
        logic signed [63:0] acc_sum;
        logic [63:0]        rb;
        logic [57:0]        num;
        logic [30:0]        t;
        logic               qbit;
        logic [28:0]        qv;

        cnt_next      = (state_next != state_reg) ? '0 : cnt_reg + CNT_W'(1);
        k_next        = k_reg;
        nsel_next     = nsel_reg;
        lpres_next    = lpres_reg;
        rpres_next    = rpres_reg;
        m_tvalid_next = m_tvalid_reg;
        lpos_next     = lpos_reg;
        rpos_next     = rpos_reg;
        lori_next     = lori_reg;
        rori_next     = rori_reg;
        lstamp_next   = lstamp_reg;
        rstamp_next   = rstamp_reg;
        diff_next     = diff_reg;
        lge_next      = lge_reg;
        side_next     = side_reg;
        prod_next     = mul_p[63:0];
        acc_next      = acc_reg;
        dot_next      = dot_reg;
        dsq_next      = dsq_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        v_next        = v_reg;
        res_next      = res_reg;
        bit_next      = bit_reg;
        rem_next      = rem_reg;
        numlo_next    = numlo_reg;
        quo_next      = quo_reg;
        nout_next     = nout_reg;
        ql_next       = ql_reg;
        qr_next       = qr_reg;
        qf_next       = qf_reg;
        fpos_next     = fpos_reg;
        mkind_next    = mkind_reg;
        mstamp_next   = mstamp_reg;
        mpos_next     = mpos_reg;
        mq_next       = mq_reg;

        for (int i = 0; i < 4; i++) begin
            case (nsel_reg)
                NS_LEFT:  src[i] = 64'(lori_reg[i]);
                NS_RIGHT: src[i] = 64'(rori_reg[i]);
                NS_FUSED: src[i] = 64'(qf_reg[i]);
                default:  src[i] = side_reg ? 64'(rori_reg[i]) : 64'(lori_reg[i]);
            endcase
        end
        acc_sum = acc_reg + prod_reg;
        rb      = res_reg + bit_reg;
        num     = 58'({mag_reg[k_reg][28:0], 28'b0}) + 58'(res_reg[29:1]);
        t       = {rem_reg, numlo_reg[28]};
        qbit    = (t >= {1'b0, res_reg[29:0]});
        qv      = {quo_reg[27:0], qbit};

        if (m_tready) m_tvalid_next = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    side_next = s_tuser[0];
                    if (s_tuser[0]) begin
                        rpres_next  = 1'b1;
                        rstamp_next = s_tdata[STAMP_W-1:0];
                        for (int i = 0; i < 3; i++) begin
                            rpos_next[i] = s_tdata[IPOS_LO + i * PW +: PW];
                        end
                        for (int i = 0; i < 4; i++) begin
                            rori_next[i] = s_tdata[IQ_LO + i * QW +: QW];
                        end
                    end else begin
                        lpres_next  = 1'b1;
                        lstamp_next = s_tdata[STAMP_W-1:0];
                        for (int i = 0; i < 3; i++) begin
                            lpos_next[i] = s_tdata[IPOS_LO + i * PW +: PW];
                        end
                        for (int i = 0; i < 4; i++) begin
                            lori_next[i] = s_tdata[IQ_LO + i * QW +: QW];
                        end
                    end
                end
            end
            ST_CHECK: begin
                lge_next  = (lstamp_reg >= rstamp_reg);
                diff_next = (lstamp_reg >= rstamp_reg) ? lstamp_reg - rstamp_reg
                                                       : rstamp_reg - lstamp_reg;
            end
            ST_DSQ: begin
                if (cnt_reg == '0) begin
                    acc_next = '0;
                end else begin
                    acc_next = acc_reg + $signed({16'b0, prod_reg[63:16]});
                    if (cnt_reg == CNT_W'(3)) begin
                        dsq_next  = acc_next[49:0];
                        nsel_next = NS_LEFT;
                    end
                end
            end
            ST_N_LOAD: begin
                k_next = '0;
                for (int i = 0; i < 4; i++) begin
                    neg_next[i] = src[i][63];
                    mag_next[i] = src[i][63] ? 64'(-src[i]) : 64'(src[i]);
                end
            end
            ST_N_SHIFT: begin
                if (sh_zero) begin
                    // zero quaternion reads as identity
                    for (int i = 0; i < 3; i++) nout_next[i] = '0;
                    nout_next[3] = $signed(Q_ONE);
                end else if (sh_right) begin
                    for (int i = 0; i < 4; i++) mag_next[i] = mag_reg[i] >> 1;
                end else if (sh_left) begin
                    for (int i = 0; i < 4; i++) mag_next[i] = mag_reg[i] << 1;
                end
            end
            ST_N_SQ: begin
                if (cnt_reg == '0) begin
                    acc_next = '0;
                end else begin
                    acc_next = acc_sum;
                    if (cnt_reg == CNT_W'(4)) begin
                        v_next   = acc_sum;
                        res_next = '0;
                        bit_next = 64'd1 << 62;
                    end
                end
            end
            ST_N_SQRT: begin
                if (v_reg >= rb) begin
                    v_next   = v_reg - rb;
                    res_next = (res_reg >> 1) + bit_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end
            ST_N_DIVI: begin
                rem_next   = 30'(num[57:29]);
                numlo_next = num[28:0];
                quo_next   = '0;
            end
            ST_N_DIV: begin
                rem_next   = qbit ? 30'(t - {1'b0, res_reg[29:0]}) : t[29:0];
                numlo_next = numlo_reg << 1;
                quo_next   = qv;
                if (cnt_reg == CNT_W'(28)) begin
                    nout_next[k_reg] = neg_reg[k_reg] ? -$signed(30'(qv)) : $signed(30'(qv));
                    k_next = k_reg + 2'd1;
                end
            end
            ST_N_DONE: begin
                case (nsel_reg)
                    NS_LEFT: begin
                        ql_next   = nout_reg;
                        nsel_next = NS_RIGHT;
                    end
                    NS_RIGHT: qr_next = nout_reg;
                    default: ;
                endcase
            end
            ST_DOT: begin
                if (cnt_reg == '0) begin
                    acc_next = '0;
                end else begin
                    acc_next = acc_sum;
                    if (cnt_reg == CNT_W'(4)) dot_next = acc_sum;
                end
            end
            ST_GATE: begin
                // align hemispheres before the blend
                if (gate_pass && dot_reg[63]) begin
                    for (int i = 0; i < 4; i++) qr_next[i] = -qr_reg[i];
                end
            end
            ST_BLEND: begin
                if (cnt_reg != '0) begin
                    if (!jx[0]) begin
                        acc_next = prod_reg + 64'sd32768;
                    end else begin
                        fpos_next[jx[2:1]] = acc_sum[47:16];
                    end
                end
            end
            ST_QBLEND: begin
                if (cnt_reg != '0) begin
                    if (!jx[0]) begin
                        acc_next = prod_reg;
                    end else begin
                        qf_next[jx[2:1]] = acc_sum[46:0];
                    end
                    if (cnt_reg == CNT_W'(8)) nsel_next = NS_FUSED;
                end
            end
            ST_SINGLE: nsel_next = NS_CUR;
            ST_EMIT: begin
                if (emit_fire) begin
                    m_tvalid_next = 1'b1;
                    for (int i = 0; i < 4; i++) mq_next[i] = nout_reg[i];
                    if (nsel_reg == NS_FUSED) begin
                        mkind_next  = KIND_FUSED;
                        mstamp_next = lge_reg ? lstamp_reg : rstamp_reg;
                        mpos_next   = fpos_reg;
                    end else begin
                        mkind_next  = side_reg ? KIND_RIGHT : KIND_LEFT;
                        mstamp_next = side_reg ? rstamp_reg : lstamp_reg;
                        for (int i = 0; i < 3; i++) begin
                            mpos_next[i] = side_reg ? OPOS_W'(rpos_reg[i])
                                                    : OPOS_W'(lpos_reg[i]);
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg       <= SYNC_WINDOW_RST;
            pgate_reg     <= POSITION_GATE_RST;
            agate_reg     <= ANGLE_GATE_RST;
            wl_reg        <= LEFT_SHARE_RST;
            single_en_reg <= 1'b1;
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            k_reg         <= '0;
            nsel_reg      <= NS_LEFT;
            lpres_reg     <= 1'b0;
            rpres_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            win_reg       <= win_next;
            pgate_reg     <= pgate_next;
            agate_reg     <= agate_next;
            wl_reg        <= wl_next;
            single_en_reg <= single_en_next;
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            nsel_reg      <= nsel_next;
            lpres_reg     <= lpres_next;
            rpres_reg     <= rpres_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lpos_reg   <= lpos_next;
        rpos_reg   <= rpos_next;
        lori_reg   <= lori_next;
        rori_reg   <= rori_next;
        lstamp_reg <= lstamp_next;
        rstamp_reg <= rstamp_next;
        diff_reg   <= diff_next;
        lge_reg    <= lge_next;
        side_reg   <= side_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        dot_reg    <= dot_next;
        dsq_reg    <= dsq_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        v_reg      <= v_next;
        res_reg    <= res_next;
        bit_reg    <= bit_next;
        rem_reg    <= rem_next;
        numlo_reg  <= numlo_next;
        quo_reg    <= quo_next;
        nout_reg   <= nout_next;
        ql_reg     <= ql_next;
        qr_reg     <= qr_next;
        qf_reg     <= qf_next;
        fpos_reg   <= fpos_next;
        mkind_reg  <= mkind_next;
        mstamp_reg <= mstamp_next;
        mpos_reg   <= mpos_next;
        mq_reg     <= mq_next;
    end

endmodule

// ===== src/dpgf_checker.sv =====
module dpgf_checker
    import dpgf_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               pready,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [ODATA_W-1:0] m_tdata,
    input logic [1:0]         m_tuser
);

    localparam int QW_LO = OQ_LO + 3 * OQ_W;

    // the block works on one pose at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a pose is in progress");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_kind_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == KIND_FUSED) || (m_tuser == KIND_LEFT) ||
                     (m_tuser == KIND_RIGHT))
        else $error("bad result kind");

    a_unit_w: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[QW_LO +: OQ_W]) <= $signed(Q_ONE)) &&
                     ($signed(m_tdata[QW_LO +: OQ_W]) >= -$signed(Q_ONE)))
        else $error("quaternion w beyond unit range");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready dropped");

endmodule

bind dual_pose_gated_fusion_unit dpgf_checker u_dpgf_checker (.*);
